@@ design/tgad_pkg.sv @@
package tgad_pkg;

    localparam int HDR_LEN       = 18;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] pixel_addr;
        logic [7:0]  run_count;
        logic [31:0] argb;
        logic [15:0] img_width;
        logic [15:0] img_height;
        logic [2:0]  error_code;
        logic        last;
    } t_out;

    localparam logic [1:0] KIND_RUN   = 2'd0;
    localparam logic [1:0] KIND_SIZE  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SIZE     = 3'd1;
    localparam logic [2:0] ERR_TYPE     = 3'd2;
    localparam logic [2:0] ERR_MAP      = 3'd3;
    localparam logic [2:0] ERR_TOOLARGE = 3'd4;

    localparam logic [7:0] HDR_TYPE_MAPPED    = 8'd1;
    localparam logic [7:0] HDR_TYPE_TRUE      = 8'd2;
    localparam logic [7:0] HDR_TYPE_MAPPED_RL = 8'd9;
    localparam logic [7:0] HDR_TYPE_TRUE_RL   = 8'd10;
    localparam logic [7:0] DEPTH_24           = 8'd24;
    localparam logic [7:0] DEPTH_32           = 8'd32;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP_ID,
        PH_MAP,
        PH_PACKET,
        PH_PIXEL,
        PH_DRAIN
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_HCHK,
        S_PRD,
        S_SEG,
        S_PUT,
        S_DONE,
        S_EOF
    } t_state;

    function automatic logic [31:0] to_argb(input logic [31:0] acc, input logic four);
        return four ? acc : {8'hFF, acc[23:0]};
    endfunction

endpackage

@@ design/tgad_pal.sv @@
module tgad_pal
    import tgad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [PAL_AW-1:0] i_waddr,
    input  logic [31:0]       i_wdata,
    input  logic              i_re,
    input  logic [PAL_AW-1:0] i_raddr,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [PALETTE_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/targa_image_decoder.sv @@
// Targa decoder: one file byte per beat, results through a one-deep output register.
// A byte is taken and worked over, then each result takes a segment set-up, then address
// multiply and issue; a mapped pixel adds a palette read before the set-up.
// A new byte is taken only in the idle state, once the last one is fully worked over.
// Reset: synchronous, active low; returns to the header phase. Palette is not cleared.
module targa_image_decoder
    import tgad_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = (DW + 16 > 24) ? DW + 16 : 24;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [7:0]    r_bc, n_bc;
    logic [1:0]    r_pos, n_pos;
    logic [7:0]    r_ent, n_ent;
    logic [31:0]   r_acc, n_acc;
    logic [7:0]    r_left, n_left;
    logic          r_rep, n_rep;
    logic [DW-1:0] r_col, n_col;
    logic [DW-1:0] r_row, n_row;
    logic [DW-1:0] r_prow, n_prow;
    logic [7:0]    r_byte, n_byte;
    logic          r_eof, n_eof;
    logic [7:0]    r_cnt, n_cnt;
    logic [7:0]    r_seg, n_seg;
    logic [31:0]   r_val, n_val;
    logic          r_idx_ok, n_idx_ok;
    logic [7:0]    r_hdr [HDR_LEN];
    logic          r_ov;
    t_out          r_od;

    logic        emit;
    t_out        emit_d;
    logic        o_free;
    logic        hdr_we;
    logic        pal_we, pal_re;
    logic [31:0] pal_wdata, pal_rdata;

    logic [15:0] w, h, yorig;
    logic        mapped, rle;
    logic [7:0]  map_len;
    logic [2:0]  unit, es, pos_inc;
    logic [31:0] acc_new;
    logic [2:0]  herr;
    logic [PW-1:0] prod, addr_sum;
    logic [DW:0]   col_n;
    logic          wrap, complete;
    logic [DW-1:0] row_n;
    logic [7:0]    cnt_n;
    logic [15:0]   rem;
    logic [8:0]    ent_inc;

    assign w       = {r_hdr[13], r_hdr[12]};
    assign h       = {r_hdr[15], r_hdr[14]};
    assign yorig   = {r_hdr[11], r_hdr[10]};
    assign mapped  = (r_hdr[2][2:0] == 3'd1);
    assign rle     = (r_hdr[2] >= HDR_TYPE_MAPPED_RL);
    assign map_len = (r_hdr[1] != 8'd0) ? r_hdr[5] : 8'd0;
    assign es      = r_hdr[7][5:3];
    assign unit    = mapped ? 3'd1 : r_hdr[16][5:3];
    assign pos_inc = {1'b0, r_pos} + 3'd1;
    assign acc_new = r_acc | (32'(r_byte) << {r_pos, 3'b000});
    assign ent_inc = {1'b0, r_ent} + 9'd1;
    assign o_free  = !r_ov || i_out_ready;

    assign prod     = PW'(r_prow) * PW'(w);
    assign addr_sum = prod + PW'(r_col);
    assign col_n    = {1'b0, r_col} + (DW + 1)'(r_seg);
    assign wrap     = 17'(col_n) >= {1'b0, w};
    assign row_n    = wrap ? r_row + DW'(1) : r_row;
    assign complete = 17'(row_n) >= {1'b0, h};
    assign cnt_n    = r_cnt - r_seg;
    assign rem      = w - 16'(r_col);

    always_comb begin
        herr = ERR_NONE;
        if (w < 16'd3 || h == 16'd0) begin
            herr = ERR_SIZE;
        end else if ({1'b0, w} > 17'(MAX_DIM) || {1'b0, h} > 17'(MAX_DIM)) begin
            herr = ERR_TOOLARGE;
        end else if (r_hdr[2] != HDR_TYPE_MAPPED && r_hdr[2] != HDR_TYPE_TRUE &&
                     r_hdr[2] != HDR_TYPE_MAPPED_RL && r_hdr[2] != HDR_TYPE_TRUE_RL) begin
            herr = ERR_TYPE;
        end else if (mapped) begin
            if (r_hdr[6] != 8'd0 || r_hdr[4] != 8'd0 || r_hdr[3] != 8'd0 ||
                (r_hdr[7] != DEPTH_24 && r_hdr[7] != DEPTH_32)) begin
                herr = ERR_MAP;
            end
        end else begin
            if (r_hdr[5] != 8'd0 || r_hdr[6] != 8'd0 || r_hdr[1] != 8'd0 ||
                (r_hdr[16] != DEPTH_24 && r_hdr[16] != DEPTH_32)) begin
                herr = ERR_MAP;
            end
        end
    end

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_bc = r_bc; n_pos = r_pos; n_ent = r_ent;
        n_acc = r_acc; n_left = r_left; n_rep = r_rep; n_col = r_col; n_row = r_row;
        n_prow = r_prow; n_byte = r_byte; n_eof = r_eof; n_cnt = r_cnt; n_seg = r_seg;
        n_val = r_val; n_idx_ok = r_idx_ok;
        emit = 1'b0; emit_d = '0;
        hdr_we = 1'b0; pal_we = 1'b0; pal_re = 1'b0;
        pal_wdata = to_argb(acc_new, es == 3'd4);
        o_in_ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_in_data.data_byte;
                    n_eof   = i_in_data.end_of_file;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_EOF;
                case (r_phase)
                    PH_HEADER: begin
                        hdr_we = 1'b1;
                        n_bc   = r_bc + 8'd1;
                        if (r_bc + 8'd1 >= 8'(HDR_LEN)) begin
                            n_state = S_HCHK;
                        end
                    end
                    PH_SKIP_ID: begin
                        n_bc = r_bc + 8'd1;
                        if (r_bc + 8'd1 >= r_hdr[0]) begin
                            n_bc = 8'd0; n_acc = '0; n_pos = '0;
                            if (map_len != 8'd0) begin
                                n_phase = PH_MAP; n_ent = '0;
                            end else begin
                                n_left  = '0;
                                n_phase = rle ? PH_PACKET : PH_PIXEL;
                            end
                        end
                    end
                    PH_MAP: begin
                        n_acc = acc_new;
                        n_pos = r_pos + 2'd1;
                        if (pos_inc == es) begin
                            pal_we = 1'b1;
                            n_acc  = '0;
                            n_pos  = '0;
                            n_ent  = r_ent + 8'd1;
                            if (ent_inc >= {1'b0, map_len}) begin
                                n_left  = '0;
                                n_phase = rle ? PH_PACKET : PH_PIXEL;
                            end
                        end
                    end
                    PH_PACKET: begin
                        if (r_byte > 8'd127) begin
                            n_rep = 1'b1; n_left = r_byte - 8'd127;
                        end else begin
                            n_rep = 1'b0; n_left = r_byte + 8'd1;
                        end
                        n_pos = '0; n_acc = '0;
                        n_phase = PH_PIXEL;
                    end
                    PH_PIXEL: begin
                        n_acc = acc_new;
                        n_pos = r_pos + 2'd1;
                        if (pos_inc >= unit) begin
                            n_acc = '0;
                            n_pos = '0;
                            n_cnt = 8'd1;
                            if (rle) begin
                                if (r_rep) begin
                                    n_cnt = r_left; n_left = '0;
                                end else if (r_left != 8'd0) begin
                                    n_left = r_left - 8'd1;
                                end
                            end
                            if (mapped) begin
                                pal_re   = 1'b1;
                                n_idx_ok = acc_new[7:0] < map_len;
                                n_state  = S_PRD;
                            end else begin
                                n_val   = to_argb(acc_new, unit == 3'd4);
                                n_state = S_SEG;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_HCHK: begin
                if (o_free) begin
                    emit = 1'b1;
                    n_state = S_EOF;
                    if (herr != ERR_NONE) begin
                        emit_d.kind = KIND_ERROR;
                        emit_d.error_code = herr;
                        emit_d.last = 1'b1;
                        n_phase = PH_DRAIN;
                    end else begin
                        emit_d.kind = KIND_SIZE;
                        emit_d.img_width = w;
                        emit_d.img_height = h;
                        emit_d.last = !r_eof;
                        n_row = '0; n_col = '0; n_bc = '0;
                        if (r_hdr[0] != 8'd0) begin
                            n_phase = PH_SKIP_ID;
                        end else begin
                            n_acc = '0; n_pos = '0;
                            if (map_len != 8'd0) begin
                                n_phase = PH_MAP; n_ent = '0;
                            end else begin
                                n_left  = '0;
                                n_phase = rle ? PH_PACKET : PH_PIXEL;
                            end
                        end
                    end
                end
            end
            S_PRD: begin
                n_val   = r_idx_ok ? pal_rdata : 32'd0;
                n_state = S_SEG;
            end
            S_SEG: begin
                n_seg   = (rem > 16'(r_cnt)) ? r_cnt : rem[7:0];
                n_prow  = (yorig == 16'd0) ? h[DW-1:0] - DW'(1) - r_row : r_row;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (o_free) begin
                    emit = 1'b1;
                    emit_d.kind = KIND_RUN;
                    emit_d.pixel_addr = addr_sum[23:0];
                    emit_d.run_count = r_seg;
                    emit_d.argb = r_val;
                    emit_d.last = !complete && cnt_n == 8'd0 && !r_eof;
                    n_col = wrap ? '0 : col_n[DW-1:0];
                    n_row = row_n;
                    n_cnt = cnt_n;
                    if (complete) begin
                        n_state = S_DONE;
                    end else if (cnt_n != 8'd0) begin
                        n_state = S_SEG;
                    end else begin
                        if (rle && r_left == 8'd0) begin
                            n_phase = PH_PACKET;
                        end
                        n_state = S_EOF;
                    end
                end
            end
            S_DONE: begin
                if (o_free) begin
                    emit = 1'b1;
                    emit_d.kind = KIND_DONE;
                    emit_d.last = 1'b1;
                    n_phase = PH_DRAIN;
                    n_state = S_EOF;
                end
            end
            S_EOF: begin
                if (!r_eof) begin
                    n_state = S_IDLE;
                end else if (r_phase == PH_DRAIN || o_free) begin
                    if (r_phase == PH_HEADER) begin
                        emit = 1'b1;
                        emit_d.kind = KIND_ERROR;
                        emit_d.error_code = ERR_SIZE;
                        emit_d.last = 1'b1;
                    end else if (r_phase != PH_DRAIN) begin
                        emit = 1'b1;
                        emit_d.kind = KIND_DONE;
                        emit_d.last = 1'b1;
                    end
                    n_phase = PH_HEADER;
                    n_bc = '0; n_acc = '0; n_left = '0; n_rep = 1'b0;
                    n_row = '0; n_col = '0; n_pos = '0; n_ent = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_HEADER;
            r_bc    <= '0;
            r_pos   <= '0;
            r_ent   <= '0;
            r_acc   <= '0;
            r_left  <= '0;
            r_rep   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_eof   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_pos   <= n_pos;
            r_ent   <= n_ent;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_rep   <= n_rep;
            r_col   <= n_col;
            r_row   <= n_row;
            r_eof   <= n_eof;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prow   <= n_prow;
        r_byte   <= n_byte;
        r_cnt    <= n_cnt;
        r_seg    <= n_seg;
        r_val    <= n_val;
        r_idx_ok <= n_idx_ok;
        if (emit) begin
            r_od <= emit_d;
        end
        if (hdr_we) begin
            r_hdr[(r_bc < 8'(HDR_LEN)) ? r_bc[4:0] : 5'd0] <= r_byte;
        end
    end

    tgad_pal u_pal (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_ent),
        .i_wdata (pal_wdata),
        .i_re    (pal_re),
        .i_raddr (acc_new[7:0]),
        .o_rdata (pal_rdata)
    );

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

@@ tb/sv/tgad_checker.sv @@
module tgad_checker
    import tgad_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM     = 4096;
    localparam int MAX_RESULTS = 45;

    // decoder copy
    logic [7:0]  hdr [HDR_LEN];
    logic [31:0] pal [PALETTE_DEPTH];
    t_phase      phase;
    int          byte_cnt;
    logic [31:0] acc;
    int          pkt_left;
    bit          pkt_repeat;
    int          pix_done;
    int          row_idx;
    int          col_idx;

    t_out step_results[$];
    t_out expected_results[$];
    int   fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic int img_w();
        return {hdr[13], hdr[12]};
    endfunction

    function automatic int img_h();
        return {hdr[15], hdr[14]};
    endfunction

    function automatic bit is_mapped();
        return hdr[2][2:0] == 3'd1;
    endfunction

    function automatic bit is_rl();
        return hdr[2] >= 8'd9;
    endfunction

    function automatic int map_len();
        return (hdr[1] != 0) ? int'(hdr[5]) : 0;
    endfunction

    function automatic logic [31:0] colour(input logic [31:0] a, input int nbytes);
        return (nbytes == 4) ? a : {8'hFF, a[23:0]};
    endfunction

    task automatic emit(input logic [1:0] k, input logic [23:0] addr, input logic [7:0] cnt,
                        input logic [31:0] argb, input logic [15:0] w, input logic [15:0] h,
                        input logic [2:0] err);
        t_out r;
        r.kind = k;
        r.pixel_addr = addr;
        r.run_count = cnt;
        r.argb = argb;
        r.img_width = w;
        r.img_height = h;
        r.error_code = err;
        r.last = 1'b0;
        if (step_results.size() < MAX_RESULTS) step_results.push_back(r);
    endtask

    task automatic clear_walk();
        phase = PH_HEADER;
        byte_cnt = 0;
        acc = '0;
        pkt_left = 0;
        pkt_repeat = 0;
        pix_done = 0;
        row_idx = 0;
        col_idx = 0;
    endtask

    task automatic start_pixels();
        byte_cnt = 0;
        acc = '0;
        pkt_left = 0;
        phase = is_rl() ? PH_PACKET : PH_PIXEL;
    endtask

    task automatic after_id();
        byte_cnt = 0;
        acc = '0;
        if (map_len() > 0) phase = PH_MAP;
        else start_pixels();
    endtask

    task automatic check_header();
        int w;
        int h;
        logic [2:0] err;
        w = img_w();
        h = img_h();
        err = ERR_NONE;
        if (w < 3 || h == 0) err = ERR_SIZE;
        else if (w > MAX_DIM || h > MAX_DIM) err = ERR_TOOLARGE;
        else if (!(hdr[2] inside {HDR_TYPE_MAPPED, HDR_TYPE_TRUE, HDR_TYPE_MAPPED_RL,
                                  HDR_TYPE_TRUE_RL})) err = ERR_TYPE;
        else if (is_mapped()) begin
            if (hdr[6] != 0 || hdr[4] != 0 || hdr[3] != 0 ||
                !(hdr[7] inside {DEPTH_24, DEPTH_32})) err = ERR_MAP;
        end else begin
            if (hdr[5] != 0 || hdr[6] != 0 || hdr[1] != 0 ||
                !(hdr[16] inside {DEPTH_24, DEPTH_32})) err = ERR_MAP;
        end
        if (err != ERR_NONE) begin
            emit(KIND_ERROR, '0, '0, '0, '0, '0, err);
            phase = PH_DRAIN;
            return;
        end
        emit(KIND_SIZE, '0, '0, '0, w[15:0], h[15:0], ERR_NONE);
        pix_done = 0;
        row_idx = 0;
        col_idx = 0;
        byte_cnt = 0;
        if (hdr[0] != 0) phase = PH_SKIP_ID;
        else after_id();
    endtask

    task automatic paint(input int count, input logic [31:0] argb);
        int w;
        int h;
        int total;
        int seg;
        int row;
        w = img_w();
        h = img_h();
        total = w * h;
        while (count > 0 && pix_done < total) begin
            seg = w - col_idx;
            if (seg > count) seg = count;
            row = ({hdr[11], hdr[10]} == 16'd0) ? (h - 1 - row_idx) : row_idx;
            emit(KIND_RUN, 24'(row * w + col_idx), 8'(seg), argb, '0, '0, ERR_NONE);
            col_idx += seg;
            if (col_idx >= w) begin
                col_idx = 0;
                row_idx++;
            end
            pix_done += seg;
            count -= seg;
        end
        if (pix_done >= total) begin
            emit(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE);
            phase = PH_DRAIN;
        end
    endtask

    task automatic take_pixel_byte(input logic [7:0] b);
        int unit;
        int count;
        logic [31:0] value;
        unit = is_mapped() ? 1 : int'(hdr[16] >> 3);
        count = 1;
        acc |= {24'd0, b} << (8 * (byte_cnt % 4));
        byte_cnt++;
        if (byte_cnt < unit) return;
        byte_cnt = 0;
        if (is_mapped()) value = (int'(acc[7:0]) < map_len()) ? pal[acc[7:0]] : '0;
        else value = colour(acc, unit);
        acc = '0;
        if (is_rl()) begin
            if (pkt_repeat) begin
                count = pkt_left;
                pkt_left = 0;
            end else if (pkt_left > 0) pkt_left--;
        end
        paint(count, value);
        if (phase != PH_DRAIN && is_rl() && pkt_left == 0) phase = PH_PACKET;
    endtask

    task automatic decode_byte(input t_in x);
        int es;
        int pos;
        step_results.delete();
        case (phase)
            PH_HEADER: begin
                hdr[byte_cnt < HDR_LEN ? byte_cnt : 0] = x.data_byte;
                byte_cnt++;
                if (byte_cnt >= HDR_LEN) check_header();
            end
            PH_SKIP_ID: begin
                byte_cnt++;
                if (byte_cnt >= hdr[0]) after_id();
            end
            PH_MAP: begin
                es = hdr[7] >> 3;
                pos = byte_cnt % es;
                acc |= {24'd0, x.data_byte} << (8 * (pos % 4));
                if (pos == es - 1) begin
                    pal[(byte_cnt / es) % PALETTE_DEPTH] = colour(acc, es);
                    acc = '0;
                end
                byte_cnt++;
                if (byte_cnt >= map_len() * es) start_pixels();
            end
            PH_PACKET: begin
                if (x.data_byte > 8'd127) begin
                    pkt_repeat = 1;
                    pkt_left = x.data_byte - 127;
                end else begin
                    pkt_repeat = 0;
                    pkt_left = x.data_byte + 1;
                end
                byte_cnt = 0;
                acc = '0;
                phase = PH_PIXEL;
            end
            PH_PIXEL: take_pixel_byte(x.data_byte);
            default: ;
        endcase
        if (x.end_of_file) begin
            if (phase == PH_HEADER) emit(KIND_ERROR, '0, '0, '0, '0, '0, ERR_SIZE);
            else if (phase != PH_DRAIN) emit(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE);
            clear_walk();
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    initial begin
        fail_count = 0;
        foreach (hdr[i]) hdr[i] = '0;
        foreach (pal[i]) pal[i] = '0;
        clear_walk();
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result %p", $realtime, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.kind !== want.kind ||
                        i_out_data.pixel_addr !== want.pixel_addr ||
                        i_out_data.run_count !== want.run_count ||
                        i_out_data.argb !== want.argb ||
                        i_out_data.img_width !== want.img_width ||
                        i_out_data.img_height !== want.img_height ||
                        i_out_data.error_code !== want.error_code ||
                        i_out_data.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch expected %p got %p", $realtime, want,
                                     i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_byte(i_in_data);
        end
    end

endmodule

@@ tb/sv/targa_image_decoder_tb.sv @@
module targa_image_decoder_tb
    import tgad_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    int   fail_count;
    int   pending;

    logic [7:0] hdr [HDR_LEN];
    logic [7:0] file_q[$];
    bit   quiet;
    int   bytes_sent;
    int   stall_left;

    targa_image_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    tgad_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, end_of_file: eof};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
        file_q.delete();
    endtask

    task automatic fill_header(input logic [7:0] typ, input int w, input int h, input int yo,
                               input int depth, input int ml, input int idl);
        bit mapped;
        mapped = (typ == HDR_TYPE_MAPPED || typ == HDR_TYPE_MAPPED_RL);
        hdr[0] = 8'(idl);
        hdr[1] = mapped ? 8'd1 : 8'd0;
        hdr[2] = typ;
        hdr[3] = 8'd0;
        hdr[4] = 8'd0;
        hdr[5] = mapped ? 8'(ml) : 8'd0;
        hdr[6] = 8'd0;
        hdr[7] = mapped ? 8'(depth) : 8'd0;
        hdr[8] = 8'($urandom);
        hdr[9] = 8'($urandom);
        {hdr[11], hdr[10]} = 16'(yo);
        {hdr[13], hdr[12]} = 16'(w);
        {hdr[15], hdr[14]} = 16'(h);
        hdr[16] = mapped ? 8'd8 : 8'(depth);
        hdr[17] = 8'($urandom);
    endtask

    task automatic queue_header();
        foreach (hdr[i]) file_q.push_back(hdr[i]);
    endtask

    // header only, ending the file on its last byte
    task automatic send_header_only();
        queue_header();
        send_file();
    endtask

    // tail: 0 whole file, 1 cut short, 2 with surplus bytes, other random
    task automatic send_image(input logic [7:0] typ, input int w, input int h, input int yo,
                              input int depth, input int ml, input int idl, input bit big,
                              input int tail);
        bit mapped;
        bit rl;
        int unit;
        int done_px;
        int cnt;
        bit rep;
        int t;
        mapped = (typ == HDR_TYPE_MAPPED || typ == HDR_TYPE_MAPPED_RL);
        rl = typ >= HDR_TYPE_MAPPED_RL;
        fill_header(typ, w, h, yo, depth, ml, idl);
        queue_header();
        repeat (idl) file_q.push_back(8'($urandom));
        if (mapped) repeat (ml * depth / 8) file_q.push_back(8'($urandom));
        unit = mapped ? 1 : depth / 8;
        done_px = 0;
        while (done_px < w * h) begin
            cnt = 1;
            rep = 1;
            if (rl) begin
                cnt = big ? 128 : $urandom_range(1, 5);
                rep = big || $urandom_range(0, 1);
                file_q.push_back(rep ? 8'(127 + cnt) : 8'(cnt - 1));
            end
            repeat (rep ? 1 : cnt) begin
                if (mapped) file_q.push_back(8'($urandom_range(0, ml + 1)));
                else repeat (unit) file_q.push_back(8'($urandom));
            end
            done_px += cnt;
        end
        t = tail;
        if (t < 0 || t > 2) t = ($urandom_range(0, 7) == 0) ? 1 :
                                ($urandom_range(0, 6) == 0) ? 2 : 0;
        if (t == 1) repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
        if (t == 2) repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
        send_file();
    endtask

    task automatic random_image();
        logic [7:0] typ;
        bit mapped;
        int depth;
        case ($urandom_range(0, 3))
            0: typ = HDR_TYPE_MAPPED;
            1: typ = HDR_TYPE_TRUE;
            2: typ = HDR_TYPE_MAPPED_RL;
            default: typ = HDR_TYPE_TRUE_RL;
        endcase
        mapped = (typ == HDR_TYPE_MAPPED || typ == HDR_TYPE_MAPPED_RL);
        depth = $urandom_range(0, 1) ? 24 : 32;
        send_image(typ, $urandom_range(3, 6), $urandom_range(1, 3),
                   $urandom_range(0, 1) ? 0 : $urandom_range(1, 65535), depth,
                   mapped ? $urandom_range(0, 6) : 0, $urandom_range(0, 2) ? 0 :
                   $urandom_range(1, 3), $urandom_range(0, 15) == 0, -1);
    endtask

    initial begin
        int total;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        quiet = 1'b0;
        bytes_sent = 0;
        stall_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // header checks
        fill_header(HDR_TYPE_TRUE, 2, 1, 0, 24, 0, 0);
        send_header_only();
        fill_header(HDR_TYPE_TRUE, 3, 0, 0, 24, 0, 0);
        send_header_only();
        fill_header(HDR_TYPE_TRUE, 4097, 1, 0, 24, 0, 0);
        send_header_only();
        fill_header(HDR_TYPE_TRUE, 3, 65535, 0, 24, 0, 0);
        send_header_only();
        fill_header(8'd3, 4, 4, 0, 24, 0, 0);
        send_header_only();
        fill_header(HDR_TYPE_MAPPED, 4, 4, 0, 24, 2, 0);
        hdr[6] = 8'd1;
        send_header_only();
        fill_header(HDR_TYPE_MAPPED, 4, 4, 0, 16, 2, 0);
        send_header_only();
        fill_header(HDR_TYPE_TRUE, 4, 4, 0, 16, 0, 0);
        send_header_only();
        fill_header(HDR_TYPE_TRUE, 4, 4, 0, 32, 0, 0);
        hdr[1] = 8'd1;
        send_header_only();
        // truncated header
        repeat (5) file_q.push_back(8'hFF);
        send_file();

        // images
        send_image(HDR_TYPE_MAPPED, 3, 2, 0, 24, 3, 2, 0, 0);
        send_image(HDR_TYPE_MAPPED_RL, 4096, 1, 0, 24, 2, 0, 1, 0);
        send_image(HDR_TYPE_MAPPED_RL, 3, 2, 7, 32, 4, 0, 1, 0);
        send_image(HDR_TYPE_TRUE_RL, 5, 3, 0, 32, 0, 1, 0, 1);
        send_image(HDR_TYPE_TRUE, 3, 1, 0, 24, 0, 7, 0, 2);

        // random files, some of them noise
        while (bytes_sent < 450) begin
            if (bytes_sent > 410) quiet = 1'b1;
            if ($urandom_range(0, 6) == 0) begin
                total = $urandom_range(1, 30);
                repeat (total) file_q.push_back(8'($urandom));
                send_file();
            end else begin
                random_image();
            end
        end
        quiet = 1'b1;
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
